[design/sdpq_pkg.sv]
`default_nettype none

package sdpq_pkg;

	// Default sizes of the block.
	localparam int DEF_MAX_WIDTH    = 1024;
	localparam int DEF_PALETTE_SIZE = 256;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int IW_BITS    = 11;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ENABLE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_THRESHOLD   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_INDEX = 2'd3;

	// Item kinds.
	localparam logic REQ_PALETTE = 1'b0;
	localparam logic REQ_PIXEL   = 1'b1;

	// Stored error per channel: signed and saturated.
	localparam int ERR_W = 10;
	localparam logic signed [10:0] ERR_MIN = -11'sd512;
	localparam logic signed [10:0] ERR_MAX = 11'sd511;

	// Share rounding: (err*w + 21) / 42, truncated toward zero.
	localparam logic signed [12:0] SHARE_BIAS = 13'sd21;
	localparam int SHARE_DEN = 42;
	localparam int DIV_SHIFT = 22;
	localparam int DIV_MUL_I = ((1 << DIV_SHIFT) + SHARE_DEN - 1) / SHARE_DEN;
	localparam logic [16:0] DIV_MUL = 17'(DIV_MUL_I);

	// Diffusion taps: three rows, twelve neighbors.
	localparam int NUM_TAPS = 12;
	localparam int TAP_W    = 4;

	typedef struct packed {
		logic [1:0]        row_off;
		logic signed [2:0] dcol;
		logic [1:0]        shift;
	} tap_t;

	// Commands to the error store.
	typedef enum logic [1:0] {
		OP_READ,
		OP_CLR_ALL,
		OP_CLR_ROW,
		OP_DIFFUSE
	} op_t;

	typedef struct packed {
		logic              valid;
		op_t               op;
		logic [1:0]        base;
		logic signed [8:0] err_r;
		logic signed [8:0] err_g;
		logic signed [8:0] err_b;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sts_t;

	// Palette write request.
	typedef struct packed {
		logic        we;
		logic [7:0]  addr;
		logic [23:0] rgb;
	} pal_wr_t;

	// Physical row for a row offset from the current row.
	function automatic logic [1:0] row_sel(input logic [1:0] base, input logic [1:0] off);
		logic [2:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= 3'd3) begin
			s = s - 3'd3;
		end
		return s[1:0];
	endfunction

	// Stucki weights: row offset, column offset and weight as a shift.
	function automatic tap_t tap_info(input logic [TAP_W-1:0] idx);
		tap_t t;
		case (idx)
			4'd0:    t = '{row_off: 2'd0, dcol:  3'sd1, shift: 2'd3};
			4'd1:    t = '{row_off: 2'd0, dcol:  3'sd2, shift: 2'd2};
			4'd2:    t = '{row_off: 2'd1, dcol: -3'sd2, shift: 2'd1};
			4'd3:    t = '{row_off: 2'd1, dcol: -3'sd1, shift: 2'd2};
			4'd4:    t = '{row_off: 2'd1, dcol:  3'sd0, shift: 2'd3};
			4'd5:    t = '{row_off: 2'd1, dcol:  3'sd1, shift: 2'd2};
			4'd6:    t = '{row_off: 2'd1, dcol:  3'sd2, shift: 2'd1};
			4'd7:    t = '{row_off: 2'd2, dcol: -3'sd2, shift: 2'd0};
			4'd8:    t = '{row_off: 2'd2, dcol: -3'sd1, shift: 2'd1};
			4'd9:    t = '{row_off: 2'd2, dcol:  3'sd0, shift: 2'd2};
			4'd10:   t = '{row_off: 2'd2, dcol:  3'sd1, shift: 2'd1};
			4'd11:   t = '{row_off: 2'd2, dcol:  3'sd2, shift: 2'd0};
			default: t = '{row_off: 2'd0, dcol:  3'sd0, shift: 2'd0};
		endcase
		return t;
	endfunction

	// One share of the error; the division by 42 is a reciprocal multiply.
	function automatic logic signed [6:0] share_div(input logic signed [8:0] err,
			input logic [1:0] shift);
		logic signed [12:0] ex;
		logic signed [12:0] n;
		logic signed [12:0] nn;
		logic [11:0] mag;
		logic [28:0] prod;
		logic [5:0]  q;
		ex   = {{4{err[8]}}, err};
		n    = (ex <<< shift) + SHARE_BIAS;
		nn   = -n;
		mag  = n[12] ? nn[11:0] : n[11:0];
		prod = mag * DIV_MUL;
		q    = prod[DIV_SHIFT+5:DIV_SHIFT];
		return n[12] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

endpackage

`default_nettype wire

[design/sdpq_palette_search.sv]
`default_nettype none

module sdpq_palette_search import sdpq_pkg::*; #(
	parameter int PALETTE_SIZE = DEF_PALETTE_SIZE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  pal_wr_t     pal_wr,
	input  logic        start,
	input  logic [23:0] val,
	output logic        done,
	output logic [7:0]  best_idx,
	output logic [23:0] best_rgb
);

	localparam int PW = $clog2(PALETTE_SIZE);
	localparam int DIST_W = 26;
	localparam logic [9:0] LUMA_R = 10'd299;
	localparam logic [9:0] LUMA_G = 10'd587;
	localparam logic [9:0] LUMA_B = 10'd114;

	logic [23:0] pal_mem [0:PALETTE_SIZE-1];

	logic          scan_q;
	logic [PW-1:0] addr_q;
	logic          v_s1, v_s2, v_s3;
	logic          last_s1, last_s2, last_s3;
	logic [PW-1:0] idx_s1, idx_s2, idx_s3;
	logic [23:0]   rgb_s1, rgb_s2, rgb_s3;
	logic [15:0]   sq_r_s2, sq_g_s2, sq_b_s2;
	logic [DIST_W-1:0] dist_s3;
	logic [DIST_W-1:0] best_d_q;
	logic [PW-1:0] best_idx_q;
	logic [23:0]   best_rgb_q;
	logic          done_q;

	logic signed [8:0]  dr, dg, db;
	logic signed [17:0] pr, pg, pb;
	logic [DIST_W-1:0]  dist_c;
	logic               last_addr;

	// Palette writes are dropped beyond the table.
	always_ff @(posedge clk) begin
		if (pal_wr.we && ({1'b0, pal_wr.addr} < 9'(PALETTE_SIZE))) begin
			pal_mem[pal_wr.addr[PW-1:0]] <= pal_wr.rgb;
		end
	end

	// One entry is read per cycle during a scan.
	always_ff @(posedge clk) begin
		if (scan_q) begin
			rgb_s1 <= pal_mem[addr_q];
		end
	end

	assign last_addr = (addr_q == PW'(PALETTE_SIZE - 1));

	// Differences and squares of the entry against the pixel.
	always_comb begin
		dr = $signed({1'b0, rgb_s1[23:16]}) - $signed({1'b0, val[23:16]});
		dg = $signed({1'b0, rgb_s1[15:8]}) - $signed({1'b0, val[15:8]});
		db = $signed({1'b0, rgb_s1[7:0]}) - $signed({1'b0, val[7:0]});
		pr = dr * dr;
		pg = dg * dg;
		pb = db * db;
	end

	// Luma-weighted distance.
	assign dist_c = sq_r_s2 * LUMA_R + sq_g_s2 * LUMA_G + sq_b_s2 * LUMA_B;

	// Data path registers of the scan pipeline.
	always_ff @(posedge clk) begin
		idx_s1  <= addr_q;
		last_s1 <= last_addr;
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		rgb_s2  <= rgb_s1;
		sq_r_s2 <= pr[15:0];
		sq_g_s2 <= pg[15:0];
		sq_b_s2 <= pb[15:0];
		idx_s3  <= idx_s2;
		last_s3 <= last_s2;
		rgb_s3  <= rgb_s2;
		dist_s3 <= dist_c;
	end

	// Scan control and running minimum; the first index wins a tie.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= 1'b0;
			addr_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= scan_q;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3 && last_s3;
			if (start) begin
				scan_q <= 1'b1;
				addr_q <= '0;
			end else if (scan_q) begin
				addr_q <= addr_q + 1'b1;
				if (last_addr) begin
					scan_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			best_d_q <= '1;
		end else if (v_s3 && (dist_s3 < best_d_q)) begin
			best_d_q   <= dist_s3;
			best_idx_q <= idx_s3;
			best_rgb_q <= rgb_s3;
		end
	end

	assign done     = done_q;
	assign best_idx = 8'(best_idx_q);
	assign best_rgb = best_rgb_q;

endmodule

`default_nettype wire

[design/sdpq_err_store.sv]
`default_nettype none

module sdpq_err_store import sdpq_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	input  logic [$clog2(MAX_WIDTH)-1:0]  col,
	input  logic [$clog2(MAX_WIDTH):0]    width,
	output sts_t                          sts,
	output logic [3*ERR_W-1:0]            rd_data
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int AW    = CW + 2;
	localparam int DEPTH = 3 * (2 ** CW);
	localparam logic [AW-1:0] ALL_END = AW'(DEPTH - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CLR,
		S_RD,
		S_WR
	} st_t;

	logic [3*ERR_W-1:0] mem [0:DEPTH-1];

	st_t              st_q;
	logic [AW-1:0]    clr_q, clr_end_q;
	logic [TAP_W-1:0] tap_q;
	logic             done_q;
	logic [1:0]       base_q;
	logic [CW-1:0]    col_q;
	logic [CW:0]      width_q;
	logic signed [8:0] err_r_q, err_g_q, err_b_q;
	logic signed [6:0] sh_r_q, sh_g_q, sh_b_q;
	logic             hit_q;
	logic [AW-1:0]    wr_addr_q;
	logic [3*ERR_W-1:0] rd_q;

	tap_t               tp;
	logic [1:0]         prow;
	logic signed [CW+1:0] cpos;
	logic               hit_c;
	logic [AW-1:0]      tap_addr;
	logic               rd_en, we;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic [3*ERR_W-1:0] wr_data;

	// Saturating add of a share to one stored channel.
	function automatic logic [ERR_W-1:0] sat_add(input logic [ERR_W-1:0] e,
			input logic signed [6:0] s);
		logic signed [10:0] v;
		v = $signed({e[ERR_W-1], e}) + 11'(s);
		if (v < ERR_MIN) begin
			v = ERR_MIN;
		end else if (v > ERR_MAX) begin
			v = ERR_MAX;
		end
		return v[ERR_W-1:0];
	endfunction

	// Target entry of the current tap.
	always_comb begin
		tp       = tap_info(tap_q);
		prow     = row_sel(base_q, tp.row_off);
		cpos     = $signed({2'b00, col_q}) + $signed({{(CW-1){tp.dcol[2]}}, tp.dcol});
		hit_c    = !cpos[CW+1] && (cpos[CW:0] < width_q);
		tap_addr = {prow, cpos[CW-1:0]};
	end

	// Port selection: a single read and a single write per cycle.
	always_comb begin
		if (st_q == S_IDLE) begin
			rd_addr = {cmd.base, col};
			rd_en   = cmd.valid && (cmd.op == OP_READ);
		end else begin
			rd_addr = tap_addr;
			rd_en   = (st_q == S_RD);
		end
		we      = 1'b0;
		wr_addr = wr_addr_q;
		wr_data = {sat_add(rd_q[3*ERR_W-1:2*ERR_W], sh_r_q),
			sat_add(rd_q[2*ERR_W-1:ERR_W], sh_g_q),
			sat_add(rd_q[ERR_W-1:0], sh_b_q)};
		if (st_q == S_CLR) begin
			we      = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (st_q == S_WR) begin
			we = hit_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Command payload and per-tap shares.
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && cmd.valid && cmd.op == OP_DIFFUSE) begin
			base_q  <= cmd.base;
			col_q   <= col;
			width_q <= width;
			err_r_q <= cmd.err_r;
			err_g_q <= cmd.err_g;
			err_b_q <= cmd.err_b;
		end
		if (st_q == S_RD) begin
			sh_r_q    <= share_div(err_r_q, tp.shift);
			sh_g_q    <= share_div(err_g_q, tp.shift);
			sh_b_q    <= share_div(err_b_q, tp.shift);
			hit_q     <= hit_c;
			wr_addr_q <= tap_addr;
		end
	end

	// Sequencer: clearing sweeps and read-modify-write over the taps.
	// Reset starts a sweep over the whole store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_CLR;
			clr_q     <= '0;
			clr_end_q <= ALL_END;
			tap_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (cmd.valid) begin
						case (cmd.op)
							OP_READ: begin
								done_q <= 1'b1;
							end
							OP_CLR_ALL: begin
								clr_q     <= '0;
								clr_end_q <= ALL_END;
								st_q      <= S_CLR;
							end
							OP_CLR_ROW: begin
								clr_q     <= {cmd.base, {CW{1'b0}}};
								clr_end_q <= {cmd.base, {CW{1'b1}}};
								st_q      <= S_CLR;
							end
							OP_DIFFUSE: begin
								tap_q <= '0;
								st_q  <= S_RD;
							end
							default: begin
								st_q <= S_IDLE;
							end
						endcase
					end
				end
				S_CLR: begin
					if (clr_q == clr_end_q) begin
						done_q <= 1'b1;
						st_q   <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_RD: begin
					st_q <= S_WR;
				end
				S_WR: begin
					if (tap_q == TAP_W'(NUM_TAPS - 1)) begin
						done_q <= 1'b1;
						st_q   <= S_IDLE;
					end else begin
						tap_q <= tap_q + 1'b1;
						st_q  <= S_RD;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign sts.busy = (st_q != S_IDLE);
	assign sts.done = done_q;
	assign rd_data  = rd_q;

endmodule

`default_nettype wire

[design/stucki_dither_palette_quantizer_core.sv]
// Stucki error-diffusion quantizer to a palette of up to 256 colors.
//
// Input channel (in_valid/in_ready): an item is either a palette write
// (req_type 0: red, green, blue go to entry palette_index) or a pixel
// (req_type 1). A pixel with frame_start set clears the error store first.
// Output channel (out_valid/out_ready): one color_index per pixel, none for
// palette writes. Configuration is a write port (cfg_we, cfg_index, cfg_data).
//
// A palette write goes to the palette memory as it is accepted. A pixel goes
// through the nearest-color scan, which reads one palette entry per cycle
// from the palette memory, then through twelve neighbor updates, each a read
// and then a write of the error memory. The last pixel of a row adds a sweep
// that clears all 2**clog2(MAX_WIDTH) entries of the retired error row; a
// frame start adds a sweep over all 3 * 2**clog2(MAX_WIDTH) entries.
//
// After reset the same full sweep runs with in_ready low. The result sits in
// an output register; while the receiver stalls the block accepts and
// processes the next item and holds its result until the register is free.

`default_nettype none

module stucki_dither_palette_quantizer_core import sdpq_pkg::*; #(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int PALETTE_SIZE = DEF_PALETTE_SIZE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic                  frame_start,
	input  logic [7:0]            palette_index,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	input  logic [7:0]            alpha,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            color_index
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WCMP_W = (CW + 1 > IW_BITS) ? CW + 1 : IW_BITS;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_W_FS,
		ST_CHECK,
		ST_W_PRE,
		ST_W_RD,
		ST_SRCH,
		ST_W_DIF,
		ST_W_POST,
		ST_OUT
	} state_t;

	state_t        state_q;
	logic          alpha_enable_q;
	logic [IW_BITS-1:0] image_width_q;
	logic [7:0]    alpha_threshold_q;
	logic [7:0]    transparent_index_q;
	logic [CW-1:0] column_q;
	logic [1:0]    row_base_q;
	logic [23:0]   px_q;
	logic          transp_q;
	logic [23:0]   val_q;
	logic [7:0]    res_q;
	logic          out_valid_q;
	logic [7:0]    color_index_q;
	logic          start_q;
	cmd_t          cmd_q;

	logic          accept;
	pal_wr_t       pal_wr;
	sts_t          sts;
	logic [3*ERR_W-1:0] cur_err;
	logic          srch_done;
	logic [7:0]    best_idx;
	logic [23:0]   best_rgb;
	logic [WCMP_W-1:0] iw_ext;
	logic [CW:0]   width_eff;
	logic [CW:0]   col_next;
	logic [23:0]   val_c;
	logic signed [8:0] err_r, err_g, err_b;

	// Clamp of a channel plus its pending error to 0..255.
	function automatic logic [7:0] clamp_px(input logic [7:0] px, input logic [ERR_W-1:0] e);
		logic signed [10:0] v;
		v = $signed({3'b000, px}) + $signed({e[ERR_W-1], e});
		if (v < 11'sd0) begin
			return 8'd0;
		end else if (v > 11'sd255) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign pal_wr.we   = accept && (req_type == REQ_PALETTE);
	assign pal_wr.addr = palette_index;
	assign pal_wr.rgb  = {red, green, blue};

	// Row width limited to 1..MAX_WIDTH.
	always_comb begin
		iw_ext = WCMP_W'(image_width_q);
		if (iw_ext == '0) begin
			width_eff = (CW+1)'(1);
		end else if (iw_ext > WCMP_W'(MAX_WIDTH)) begin
			width_eff = (CW+1)'(MAX_WIDTH);
		end else begin
			width_eff = iw_ext[CW:0];
		end
	end

	assign col_next = {1'b0, column_q} + 1'b1;

	always_comb begin
		val_c = {clamp_px(px_q[23:16], cur_err[3*ERR_W-1:2*ERR_W]),
			clamp_px(px_q[15:8], cur_err[2*ERR_W-1:ERR_W]),
			clamp_px(px_q[7:0], cur_err[ERR_W-1:0])};
		err_r = $signed({1'b0, val_q[23:16]}) - $signed({1'b0, best_rgb[23:16]});
		err_g = $signed({1'b0, val_q[15:8]}) - $signed({1'b0, best_rgb[15:8]});
		err_b = $signed({1'b0, val_q[7:0]}) - $signed({1'b0, best_rgb[7:0]});
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_enable_q      <= 1'b0;
			image_width_q       <= 11'd1024;
			alpha_threshold_q   <= 8'd192;
			transparent_index_q <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALPHA_ENABLE:      alpha_enable_q      <= cfg_data[0];
				REG_IMAGE_WIDTH:       image_width_q       <= cfg_data;
				REG_ALPHA_THRESHOLD:   alpha_threshold_q   <= cfg_data[7:0];
				REG_TRANSPARENT_INDEX: transparent_index_q <= cfg_data[7:0];
				default:               alpha_enable_q      <= alpha_enable_q;
			endcase
		end
	end

	// Pixel sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
			start_q     <= 1'b0;
			cmd_q       <= '0;
			column_q    <= '0;
			row_base_q  <= '0;
		end else begin
			cmd_q.valid <= 1'b0;
			start_q     <= 1'b0;
			// The output state reloads the register itself when it is taken.
			if (out_valid_q && out_ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (sts.done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && req_type == REQ_PIXEL) begin
						px_q     <= {red, green, blue};
						transp_q <= alpha_enable_q && (alpha < alpha_threshold_q);
						if (frame_start) begin
							column_q    <= '0;
							row_base_q  <= '0;
							cmd_q.valid <= 1'b1;
							cmd_q.op    <= OP_CLR_ALL;
							state_q     <= ST_W_FS;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_W_FS: begin
					if (sts.done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					cmd_q.valid <= 1'b1;
					cmd_q.base  <= row_base_q;
					if ({1'b0, column_q} >= width_eff) begin
						// Row ended early: retire it before the pixel.
						cmd_q.op   <= OP_CLR_ROW;
						row_base_q <= row_sel(row_base_q, 2'd1);
						column_q   <= '0;
						state_q    <= ST_W_PRE;
					end else begin
						cmd_q.op <= OP_READ;
						state_q  <= ST_W_RD;
					end
				end
				ST_W_PRE: begin
					if (sts.done) begin
						cmd_q.valid <= 1'b1;
						cmd_q.op    <= OP_READ;
						cmd_q.base  <= row_base_q;
						state_q     <= ST_W_RD;
					end
				end
				ST_W_RD: begin
					if (sts.done) begin
						val_q   <= val_c;
						start_q <= 1'b1;
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (srch_done) begin
						cmd_q.valid <= 1'b1;
						cmd_q.op    <= OP_DIFFUSE;
						cmd_q.base  <= row_base_q;
						cmd_q.err_r <= err_r;
						cmd_q.err_g <= err_g;
						cmd_q.err_b <= err_b;
						res_q       <= transp_q ? transparent_index_q : best_idx;
						state_q     <= ST_W_DIF;
					end
				end
				ST_W_DIF: begin
					if (sts.done) begin
						if (col_next >= width_eff) begin
							cmd_q.valid <= 1'b1;
							cmd_q.op    <= OP_CLR_ROW;
							cmd_q.base  <= row_base_q;
							row_base_q  <= row_sel(row_base_q, 2'd1);
							column_q    <= '0;
							state_q     <= ST_W_POST;
						end else begin
							column_q <= col_next[CW-1:0];
							state_q  <= ST_OUT;
						end
					end
				end
				ST_W_POST: begin
					if (sts.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						color_index_q <= res_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	sdpq_palette_search #(
		.PALETTE_SIZE(PALETTE_SIZE)
	) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.pal_wr   (pal_wr),
		.start    (start_q),
		.val      (val_q),
		.done     (srch_done),
		.best_idx (best_idx),
		.best_rgb (best_rgb)
	);

	sdpq_err_store #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_q),
		.col     (column_q),
		.width   (width_eff),
		.sts     (sts),
		.rd_data (cur_err)
	);

	assign out_valid   = out_valid_q;
	assign color_index = color_index_q;

	// The store is never busy while a new item can come in.
	a_ready_store_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !sts.busy) else $error("item accepted while error store busy");

	// A scan ends only while the sequencer waits for it.
	a_search_done: assert property (@(posedge clk) disable iff (!arst_n)
		srch_done |-> (state_q == ST_SRCH)) else $error("unexpected end of palette scan");

	// Store completions arrive only in waiting states.
	a_store_done: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> (state_q == ST_INIT || state_q == ST_W_FS || state_q == ST_W_PRE ||
			state_q == ST_W_RD || state_q == ST_W_DIF || state_q == ST_W_POST))
		else $error("unexpected error store completion");

	// The column stays inside the store's row.
	a_column_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, column_q} < (CW+1)'(MAX_WIDTH)) else $error("column out of range");

endmodule

`default_nettype wire
